@@ src/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned ROW_BITS = 32;
  localparam int unsigned ROW_SH   = 5;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_SPACE  = 2'd2,
    STAT_NOT_ALLOC = 2'd3
  } stat_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_INIT,
    ST_IDLE,
    ST_A_CHK,
    ST_A_LVL,
    ST_A_RD,
    ST_A_ROW,
    ST_A_DESC,
    ST_SP_RD,
    ST_SP_WR,
    ST_A_TAG,
    ST_A_ADDR,
    ST_F_ST,
    ST_F_DIV,
    ST_F_IDX,
    ST_F_TAG,
    ST_M_RD,
    ST_M_WR,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic  clr_wr;
    logic  init_wr;
    logic  load;
    logic  div_start;
    logic  tag_rd;
    logic  tag_alloc;
    logic  tag_none;
    logic  row_rd;
    logic  row_sel_scan;
    logic  found_wr;
    logic  split_wr;
    logic  merge_wr;
    logic  lvl_load_want;
    logic  lvl_next;
    logic  descend;
    logic  ascend;
    logic  lvl_load_tag;
    logic  row_ctr_clr;
    logic  row_ctr_inc;
    logic  used_add;
    logic  used_sub;
    logic  mul_go;
    logic  res_set;
    logic  res_addr;
    stat_t res_code;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic too_large;
    logic over_pool;
    logic lvl_end;
    logic cnt_zero;
    logic row_nz;
    logic lvl_is_want;
    logic div_done;
    logic idx_bad;
    logic tag_bad;
    logic buddy_free;
    logic clr_last;
    logic init_last;
    logic out_full;
  } sts_t;

  // First bitmap row of a level; every level starts on a row boundary.
  function automatic int unsigned row_base(int unsigned n, int unsigned lvl);
    int unsigned s;
    s = 0;
    for (int unsigned k = 0; k < lvl; k++) begin
      s = s + (((n >> k) + ROW_BITS - 1) >> ROW_SH);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/bba_div.sv @@
// ----------------------------------------------------------------------------
// bba_div
// Divider by a power-of-two constant: one registered shift.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_div import bba_pkg::*; #(
  parameter int unsigned DIVISOR = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] dividend,
  output logic                   done,
  output logic [ADDR_W-1:0]      quotient
);

  localparam int unsigned SH = $clog2(DIVISOR);

  logic              done_r, done_nxt;
  logic [ADDR_W-1:0] quo_r, quo_nxt;

  always_comb begin
    done_nxt = start;
    quo_nxt  = quo_r;
    if (start) begin
      quo_nxt = dividend >> SH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ src/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Allocator sequencer: clearing and init passes, allocate and free flows.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl import bba_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_func,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (sts.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_func ? ST_F_ST : ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (sts.too_large) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_TOO_LARGE;
          state_nxt    = ST_DONE;
        end else if (sts.over_pool) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_NO_SPACE;
          state_nxt    = ST_DONE;
        end else begin
          cmd.lvl_load_want = 1'b1;
          state_nxt         = ST_A_LVL;
        end
      end
      ST_A_LVL: begin
        if (sts.lvl_end) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_NO_SPACE;
          state_nxt    = ST_DONE;
        end else if (sts.cnt_zero) begin
          cmd.lvl_next = 1'b1;
        end else begin
          cmd.row_ctr_clr = 1'b1;
          state_nxt       = ST_A_RD;
        end
      end
      ST_A_RD: begin
        cmd.row_rd       = 1'b1;
        cmd.row_sel_scan = 1'b1;
        state_nxt        = ST_A_ROW;
      end
      ST_A_ROW: begin
        cmd.row_sel_scan = 1'b1;
        if (sts.row_nz) begin
          cmd.found_wr = 1'b1;
          state_nxt    = ST_A_DESC;
        end else begin
          cmd.row_ctr_inc = 1'b1;
          state_nxt       = ST_A_RD;
        end
      end
      ST_A_DESC: begin
        if (sts.lvl_is_want) begin
          state_nxt = ST_A_TAG;
        end else begin
          cmd.descend = 1'b1;
          state_nxt   = ST_SP_RD;
        end
      end
      ST_SP_RD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = ST_SP_WR;
      end
      ST_SP_WR: begin
        cmd.split_wr = 1'b1;
        state_nxt    = ST_A_DESC;
      end
      ST_A_TAG: begin
        cmd.tag_alloc = 1'b1;
        cmd.used_add  = 1'b1;
        cmd.mul_go    = 1'b1;
        state_nxt     = ST_A_ADDR;
      end
      ST_A_ADDR: begin
        cmd.res_set  = 1'b1;
        cmd.res_addr = 1'b1;
        cmd.res_code = STAT_OK;
        state_nxt    = ST_DONE;
      end
      ST_F_ST: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_F_DIV;
      end
      ST_F_DIV: begin
        if (sts.div_done) state_nxt = ST_F_IDX;
      end
      ST_F_IDX: begin
        if (sts.idx_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_NOT_ALLOC;
          state_nxt    = ST_DONE;
        end else begin
          cmd.tag_rd = 1'b1;
          state_nxt  = ST_F_TAG;
        end
      end
      ST_F_TAG: begin
        if (sts.tag_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_NOT_ALLOC;
          state_nxt    = ST_DONE;
        end else begin
          cmd.tag_none     = 1'b1;
          cmd.lvl_load_tag = 1'b1;
          cmd.used_sub     = 1'b1;
          state_nxt        = ST_M_RD;
        end
      end
      ST_M_RD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = ST_M_WR;
      end
      ST_M_WR: begin
        cmd.merge_wr = 1'b1;
        if (sts.buddy_free) begin
          cmd.ascend = 1'b1;
          state_nxt  = ST_M_RD;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = STAT_OK;
          state_nxt    = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/bba_dp.sv @@
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: level bitmaps, free counts, tag store, byte total and result.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp import bba_pkg::*; #(
  parameter int unsigned NUM_MIN_BLOCKS  = 1024,
  parameter int unsigned MIN_BLOCK_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_wr_data,
  input  wire logic [SIZE_W-1:0] in_request_size,
  input  wire logic [ADDR_W-1:0] in_block_address,
  input  wire logic              out_stall,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [ADDR_W-1:0]      out_result_address
);

  localparam int unsigned N     = NUM_MIN_BLOCKS;
  localparam int unsigned MB    = MIN_BLOCK_BYTES;
  localparam int unsigned LVLS  = $clog2(N + 1);
  localparam int unsigned LIW   = $clog2(LVLS);
  localparam int unsigned LW    = $clog2(LVLS + 1);
  localparam int unsigned OW    = $clog2(N);
  localparam int unsigned TW    = LIW + 1;
  localparam int unsigned ROWS  = row_base(N, LVLS);
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW    = $clog2(N + 1);
  localparam longint unsigned POOL = longint'(N) * longint'(MB);
  localparam int unsigned UW    = $clog2(POOL + 1);
  localparam int unsigned CLRN  = (ROWS > N) ? ROWS : N;
  localparam int unsigned CNW   = $clog2(CLRN);
  localparam int unsigned MBW   = $clog2(MB + 1);
  localparam int unsigned MULW  = OW + MBW;
  localparam logic [TW-1:0] TAG_NONE = {TW{1'b1}};

  // per-level constants
  logic [RW-1:0]       row_base_w  [LVLS];
  logic [RW-1:0]       init_row_w  [LVLS];
  logic [ROW_BITS-1:0] init_word_w [LVLS];
  logic                init_en_w   [LVLS];

  for (genvar g = 0; g < LVLS; g++) begin : g_lvl
    localparam int unsigned CNT = N >> g;
    assign row_base_w[g]  = RW'(row_base(N, g));
    assign init_en_w[g]   = ((CNT & 1) != 0);
    assign init_row_w[g]  = RW'(row_base(N, g) + ((CNT - 1) >> ROW_SH));
    assign init_word_w[g] = ROW_BITS'(1) << ((CNT - 1) % ROW_BITS);
  end

  logic [ADDR_W-1:0]   base_r;
  logic [ADDR_W-1:0]   addr_in_r;
  logic [LW-1:0]       want_r;
  logic                too_large_r;
  logic [LW-1:0]       lvl_r;
  logic [OW-1:0]       off_r;
  logic [RW-1:0]       row_ctr_r;
  logic [CNW-1:0]      sweep_r;
  logic [LIW-1:0]      init_r;
  logic [CW-1:0]       cnt_r [LVLS];
  logic [UW-1:0]       used_r;
  logic [ROW_BITS-1:0] rd_q;
  logic [TW-1:0]       tag_q;
  logic [ADDR_W-1:0]   mul_r;
  stat_t               res_code_r;
  logic [ADDR_W-1:0]   res_addr_r;
  logic                out_valid_r;
  stat_t               out_status_r;
  logic [ADDR_W-1:0]   out_addr_r;

  logic [ROW_BITS-1:0] fm_mem  [ROWS];
  logic [TW-1:0]       tag_mem [N];

  logic [LIW-1:0]      lvl_idx;
  logic [CW-1:0]       cur_cnt, cnt_nxt;
  logic                cnt_we;
  logic [RW-1:0]       scan_row, lo_row, rd_addr;
  logic [4:0]          fpos, opos, bpos;
  logic [OW-1:0]       found_off, alloc_idx, free_idx;
  logic                fm_we;
  logic [RW-1:0]       fm_wa;
  logic [ROW_BITS-1:0] fm_wd;
  logic                tg_we;
  logic [OW-1:0]       tg_wa;
  logic [TW-1:0]       tg_wd;
  logic [LW-1:0]       want_c;
  logic                fit_c;
  logic [UW-1:0]       bsize_want, bsize_tag;
  logic                div_done;
  logic [ADDR_W-1:0]   div_q;
  logic                out_xfer;

  assign lvl_idx   = lvl_r[LIW-1:0];
  assign cur_cnt   = cnt_r[lvl_idx];
  assign scan_row  = row_base_w[lvl_idx] + row_ctr_r;
  assign lo_row    = row_base_w[lvl_idx] + RW'(off_r >> ROW_SH);
  assign rd_addr   = cmd.row_sel_scan ? scan_row : lo_row;
  assign opos      = 5'(off_r);
  assign bpos      = opos ^ 5'd1;
  assign found_off = OW'({row_ctr_r, fpos});
  assign alloc_idx = OW'(off_r << want_r);
  assign free_idx  = div_q[OW-1:0];
  assign bsize_want = UW'(MB) << want_r;
  assign bsize_tag  = UW'(MB) << tag_q;
  assign out_xfer   = out_valid_r && !out_stall;

  // lowest free block in the scanned row
  always_comb begin
    fpos = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (rd_q[i]) fpos = 5'(i);
    end
  end

  // size rounded up to a level
  always_comb begin
    want_c = '0;
    fit_c  = 1'b0;
    for (int i = LVLS - 1; i >= 0; i--) begin
      if (64'(in_request_size) <= (64'(MB) << i)) begin
        want_c = LW'(i);
        fit_c  = 1'b1;
      end
    end
  end

  // bitmap write port
  always_comb begin
    fm_we = 1'b0;
    fm_wa = lo_row;
    fm_wd = rd_q;
    if (cmd.clr_wr) begin
      fm_we = (32'(sweep_r) < ROWS);
      fm_wa = RW'(sweep_r);
      fm_wd = '0;
    end else if (cmd.init_wr) begin
      fm_we = init_en_w[init_r];
      fm_wa = init_row_w[init_r];
      fm_wd = init_word_w[init_r];
    end else if (cmd.found_wr) begin
      fm_we = 1'b1;
      fm_wa = scan_row;
      fm_wd = rd_q & ~(ROW_BITS'(1) << fpos);
    end else if (cmd.split_wr) begin
      fm_we = 1'b1;
      fm_wd = (rd_q & ~(ROW_BITS'(1) << opos)) | (ROW_BITS'(1) << bpos);
    end else if (cmd.merge_wr) begin
      fm_we = 1'b1;
      if (rd_q[bpos]) begin
        fm_wd = rd_q & ~(ROW_BITS'(1) << opos) & ~(ROW_BITS'(1) << bpos);
      end else begin
        fm_wd = rd_q | (ROW_BITS'(1) << opos);
      end
    end
  end

  // free count of the current level follows the bit changes
  always_comb begin
    cnt_we  = 1'b0;
    cnt_nxt = cur_cnt;
    if (cmd.found_wr) begin
      cnt_we  = 1'b1;
      cnt_nxt = cur_cnt - 1'b1;
    end else if (cmd.split_wr) begin
      cnt_we  = 1'b1;
      cnt_nxt = cur_cnt - CW'(rd_q[opos]) + CW'(!rd_q[bpos]);
    end else if (cmd.merge_wr) begin
      cnt_we = 1'b1;
      if (rd_q[bpos]) begin
        cnt_nxt = cur_cnt - 1'b1 - CW'(rd_q[opos]);
      end else begin
        cnt_nxt = cur_cnt + CW'(!rd_q[opos]);
      end
    end
  end

  // tag write port
  always_comb begin
    tg_we = 1'b0;
    tg_wa = free_idx;
    tg_wd = TAG_NONE;
    if (cmd.clr_wr) begin
      tg_we = (32'(sweep_r) < N);
      tg_wa = OW'(sweep_r);
    end else if (cmd.tag_alloc) begin
      tg_we = 1'b1;
      tg_wa = alloc_idx;
      tg_wd = TW'(want_r);
    end else if (cmd.tag_none) begin
      tg_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm_mem[fm_wa] <= fm_wd;
    if (cmd.row_rd) rd_q <= fm_mem[rd_addr];
    if (tg_we) tag_mem[tg_wa] <= tg_wd;
    if (cmd.tag_rd) tag_q <= tag_mem[free_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      used_r      <= '0;
      sweep_r     <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < LVLS; j++) begin
        cnt_r[j] <= CW'((N >> j) & 1);
      end
    end else begin
      if (cfg_wr_en) base_r <= cfg_wr_data;
      if (cmd.clr_wr) sweep_r <= sweep_r + 1'b1;
      if (cmd.init_wr) init_r <= init_r + 1'b1;
      if (cnt_we) cnt_r[lvl_idx] <= cnt_nxt;
      if (cmd.used_add) begin
        used_r <= used_r + bsize_want;
      end else if (cmd.used_sub) begin
        used_r <= used_r - bsize_tag;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_in_r   <= in_block_address;
      want_r      <= want_c;
      too_large_r <= !fit_c;
    end
    if (cmd.lvl_load_want) begin
      lvl_r <= want_r;
    end else if (cmd.lvl_next || cmd.ascend) begin
      lvl_r <= lvl_r + 1'b1;
    end else if (cmd.descend) begin
      lvl_r <= lvl_r - 1'b1;
    end else if (cmd.lvl_load_tag) begin
      lvl_r <= LW'(tag_q);
    end
    if (cmd.found_wr) begin
      off_r <= found_off;
    end else if (cmd.descend) begin
      off_r <= off_r << 1;
    end else if (cmd.ascend) begin
      off_r <= off_r >> 1;
    end else if (cmd.lvl_load_tag) begin
      off_r <= free_idx >> tag_q;
    end
    if (cmd.row_ctr_clr) begin
      row_ctr_r <= '0;
    end else if (cmd.row_ctr_inc) begin
      row_ctr_r <= row_ctr_r + 1'b1;
    end
    if (cmd.mul_go) mul_r <= ADDR_W'(MULW'(alloc_idx) * MULW'(MB));
    if (cmd.res_set) begin
      res_code_r <= cmd.res_code;
      res_addr_r <= cmd.res_addr ? (base_r + mul_r) : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_code_r;
      out_addr_r   <= res_addr_r;
    end
  end

  bba_div #(
    .DIVISOR (MB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (addr_in_r - base_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    sts.too_large   = too_large_r;
    sts.over_pool   = ((UW + 1)'(used_r) + (UW + 1)'(bsize_want)) > (UW + 1)'(POOL);
    sts.lvl_end     = (lvl_r == LW'(LVLS));
    sts.cnt_zero    = (cur_cnt == '0);
    sts.row_nz      = (rd_q != '0);
    sts.lvl_is_want = (lvl_r == want_r);
    sts.div_done    = div_done;
    sts.idx_bad     = (div_q >= ADDR_W'(N));
    sts.tag_bad     = (tag_q == TAG_NONE) || (32'(tag_q) >= LVLS);
    sts.buddy_free  = rd_q[bpos];
    sts.clr_last    = (sweep_r == CNW'(CLRN - 1));
    sts.init_last   = (init_r == LIW'(LVLS - 1));
    sts.out_full    = out_valid_r && out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;

endmodule

`default_nettype wire

@@ src/buddy_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator over a pool of NUM_MIN_BLOCKS blocks of MIN_BLOCK_BYTES.
// ----------------------------------------------------------------------------
// One request at a time; each gives one result. MIN_BLOCK_BYTES must be a
// power of two. After reset the unit runs a clearing pass over its bitmap and
// tag stores, then writes each level's initial free bit, and stalls input
// meanwhile. Levels are kept as 32-bit bitmap rows in one memory, read and
// rewritten one row at a time. An allocate checks the size and the pool,
// skips levels with no free block, scans the first level that has one and
// splits down to the wanted level. A free divides the address offset by a
// registered shift, checks index and tag, then merges upward while the buddy
// is free, visiting one level more than it merges. The result sits in an
// output register; a new request is taken once it is loaded there.
`default_nettype none

module buddy_block_allocator_unit import bba_pkg::*; #(
  parameter int unsigned NUM_MIN_BLOCKS  = 1024,
  parameter int unsigned MIN_BLOCK_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_func,
  input  wire logic [SIZE_W-1:0] in_request_size,
  input  wire logic [ADDR_W-1:0] in_block_address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_status,
  output logic [ADDR_W-1:0]      out_result_address
);

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp #(
    .NUM_MIN_BLOCKS  (NUM_MIN_BLOCKS),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_request_size    (in_request_size),
    .in_block_address   (in_block_address),
    .out_stall          (out_stall),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address)
  );

endmodule

`default_nettype wire
